// File: design/dzgspi_pkg.sv
// Shared types, widths and register indexes for the dead-band PI controller.
`timescale 1ns / 1ps

package dzgspi_pkg;

    // Field and register widths
    localparam int TempW  = 16;
    localparam int ErrW   = TempW + 1;
    localparam int GainW  = 16;
    localparam int DzW    = 15;
    localparam int LimW   = 15;
    localparam int IntegW = 24;
    localparam int ProdW  = ErrW + GainW + 1;
    localparam int TermW  = ProdW - 12;
    localparam int SumW   = IntegW + 1;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    typedef logic signed [TempW-1:0] t_temp;
    typedef logic [GainW-1:0]        t_gain;
    typedef logic [DzW-1:0]          t_dz;
    typedef logic [LimW-1:0]         t_lim;
    typedef logic [CfgIdxW-1:0]      t_cfg_idx;
    typedef logic [CfgDataW-1:0]     t_cfg_data;

    // Configuration register indexes
    localparam t_cfg_idx RegSetpoint    = 3'd0;
    localparam t_cfg_idx RegDeadZone    = 3'd1;
    localparam t_cfg_idx RegKpSmall     = 3'd2;
    localparam t_cfg_idx RegKpLarge     = 3'd3;
    localparam t_cfg_idx RegKi          = 3'd4;
    localparam t_cfg_idx RegSwitchError = 3'd5;
    localparam t_cfg_idx RegDriveLimit  = 3'd6;

    // Register reset values
    localparam t_temp RstSetpoint    = 16'sd0;
    localparam t_dz   RstDeadZone    = 15'd32;
    localparam t_gain RstKpSmall     = 16'd8192;
    localparam t_gain RstKpLarge     = 16'd40960;
    localparam t_gain RstKi          = 16'd307;
    localparam t_gain RstSwitchError = 16'd256;
    localparam t_lim  RstDriveLimit  = 15'd12800;

    // Rounding offset for Q19 to Q7 (half an LSB of the result)
    localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(2048);

endpackage

// File: design/deadzone_gain_scheduled_pi_top.sv
// Top level of the dead-band, gain-scheduled PI temperature controller.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        sink       i_in_valid / o_in_stall    i_measured_temp
// out       source     o_out_valid / i_out_stall  o_drive, o_clamped
// cfg       sink       i_cfg_we                   i_cfg_index, i_cfg_data
//
// One transfer in per cycle while o_in_stall is low; each result passes the input register, then the result register.
// The input register feeds one pass of error, dead band, two multipliers, integrator
// update and clamp straight into the result register; the integrator loop closes
// in that pass. Reset is synchronous, active low, and clears the valids, the integrator
// and the configuration registers. A stalled result holds; the input register takes a
// new item while it is empty or the result register is free or being emptied.
module deadzone_gain_scheduled_pi_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  dzgspi_pkg::t_temp      i_measured_temp,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output dzgspi_pkg::t_temp      o_drive,
    output logic                   o_clamped,
    input  logic                   i_cfg_we,
    input  dzgspi_pkg::t_cfg_idx   i_cfg_index,
    input  dzgspi_pkg::t_cfg_data  i_cfg_data
);
    import dzgspi_pkg::*;

    // Configuration registers
    t_temp r_setpoint;
    t_dz   r_dead_zone;
    t_gain r_kp_small;
    t_gain r_kp_large;
    t_gain r_ki;
    t_gain r_switch_error;
    t_lim  r_drive_limit;

    // Pipeline registers
    logic                     r_in_valid;
    t_temp                    r_in_temp;
    logic                     r_out_valid;
    t_temp                    r_drive;
    logic                     r_clamped;
    logic signed [IntegW-1:0] r_integ;

    // Datapath
    logic signed [ErrW-1:0]  w_err_raw;
    logic signed [ErrW-1:0]  w_dz;
    logic signed [ErrW-1:0]  w_err;
    logic [ErrW-1:0]         w_mag;
    logic                    w_large;
    t_gain                   w_kp;
    logic signed [ProdW-1:0] w_p_prod;
    logic signed [ProdW-1:0] w_i_prod;
    logic signed [TermW-1:0] w_up;
    logic signed [TermW-1:0] w_ui_inc;
    logic signed [SumW-1:0]  w_integ_sum;
    logic signed [IntegW-1:0] w_integ_sat;
    logic signed [IntegW-1:0] n_integ;
    logic signed [IntegW-1:0] w_ui;
    logic signed [SumW-1:0]  w_u;
    logic signed [SumW-1:0]  w_lim;
    t_temp                   n_drive;
    logic                    n_clamped;
    logic                    w_advance;

    // Handshake: the result register frees when empty or when its transfer completes
    assign w_advance   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !w_advance;
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_clamped   = r_clamped;

    // Write configuration registers, keeping the low bits of the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint     <= RstSetpoint;
            r_dead_zone    <= RstDeadZone;
            r_kp_small     <= RstKpSmall;
            r_kp_large     <= RstKpLarge;
            r_ki           <= RstKi;
            r_switch_error <= RstSwitchError;
            r_drive_limit  <= RstDriveLimit;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegSetpoint:    r_setpoint     <= $signed(i_cfg_data);
                RegDeadZone:    r_dead_zone    <= i_cfg_data[DzW-1:0];
                RegKpSmall:     r_kp_small     <= i_cfg_data;
                RegKpLarge:     r_kp_large     <= i_cfg_data;
                RegKi:          r_ki           <= i_cfg_data;
                RegSwitchError: r_switch_error <= i_cfg_data;
                RegDriveLimit:  r_drive_limit  <= i_cfg_data[LimW-1:0];
                default: ;
            endcase
        end
    end

    // Form the error and apply the dead band
    always_comb begin
        w_err_raw = ErrW'(r_setpoint) - ErrW'(r_in_temp);
        w_dz      = $signed({2'b00, r_dead_zone});
        if (w_err_raw > w_dz) begin
            w_err = w_err_raw - w_dz;
        end else if (w_err_raw < -w_dz) begin
            w_err = w_err_raw + w_dz;
        end else begin
            w_err = '0;
        end
        w_mag   = w_err[ErrW-1] ? ErrW'(-w_err) : w_err;
        w_large = w_mag > {1'b0, r_switch_error};
        w_kp    = w_large ? r_kp_large : r_kp_small;
    end

    // Scale by the gains, rounding to nearest with ties upward
    always_comb begin
        w_p_prod = ProdW'($signed({1'b0, w_kp}) * w_err) + RoundHalf;
        w_i_prod = ProdW'($signed({1'b0, r_ki}) * w_err) + RoundHalf;
        w_up     = w_p_prod[ProdW-1:12];
        w_ui_inc = w_i_prod[ProdW-1:12];
    end

    // Update the integrator, saturating to its width; on a large error load the P term instead
    always_comb begin
        w_integ_sum = SumW'(r_integ) + SumW'(w_ui_inc);
        if (w_integ_sum[SumW-1] != w_integ_sum[SumW-2]) begin
            w_integ_sat = w_integ_sum[SumW-1] ? {1'b1, {(IntegW-1){1'b0}}}
                                              : {1'b0, {(IntegW-1){1'b1}}};
        end else begin
            w_integ_sat = w_integ_sum[IntegW-1:0];
        end
        if (w_large) begin
            n_integ = IntegW'(w_up);
            w_ui    = '0;
        end else begin
            n_integ = w_integ_sat;
            w_ui    = w_integ_sat;
        end
    end

    // Sum the terms and clamp to the drive limit
    always_comb begin
        w_u   = SumW'(w_up) + SumW'(w_ui);
        w_lim = $signed({{(SumW-LimW){1'b0}}, r_drive_limit});
        if (w_u > w_lim) begin
            n_drive   = w_lim[TempW-1:0];
            n_clamped = 1'b1;
        end else if (w_u < -w_lim) begin
            n_drive   = TempW'(-w_lim);
            n_clamped = 1'b1;
        end else begin
            n_drive   = w_u[TempW-1:0];
            n_clamped = 1'b0;
        end
    end

    // Advance valids and the integrator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_integ <= n_integ;
                end
            end
        end
    end

    // Capture payloads
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_temp <= i_measured_temp;
        end
        if (w_advance && r_in_valid) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

endmodule

// File: design/dzgspi_chk.sv
// Port-level checker for the dead-band PI controller, bound to the top level.
`timescale 1ns / 1ps

module dzgspi_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input dzgspi_pkg::t_temp o_drive,
    input logic              o_out_valid,
    input logic              i_out_stall
);
    import dzgspi_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_drive))
        else $error("stalled result changed");

    // Empty the result side on reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Stall the input only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // Keep the drive inside the symmetric range
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_drive != {1'b1, {(TempW-1){1'b0}}})
        else $error("drive outside symmetric range");

endmodule

bind deadzone_gain_scheduled_pi_top dzgspi_chk u_dzgspi_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_drive     (o_drive),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);
